// ===== rtl/olfp_pkg.sv =====
// ----------------------------------------------------------------------------
// olfp_pkg
// Shared types, register indexes, fixed-point constants and the quarter-wave
// sine generator for the open-loop field-oriented PWM unit.
// ----------------------------------------------------------------------------
package olfp_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_ENABLE      = 3'd0;
    localparam logic [2:0] CFG_ANGLE_STEP  = 3'd1;
    localparam logic [2:0] CFG_POLE_PAIRS  = 3'd2;
    localparam logic [2:0] CFG_ZERO_OFFSET = 3'd3;
    localparam logic [2:0] CFG_Q_DRIVE     = 3'd4;
    localparam logic [2:0] CFG_PWM_TOP     = 3'd5;

    // register reset values
    localparam logic        RST_ENABLE      = 1'b0;
    localparam logic [15:0] RST_ANGLE_STEP  = 16'd0;
    localparam logic [6:0]  RST_POLE_PAIRS  = 7'd7;
    localparam logic [15:0] RST_ZERO_OFFSET = 16'd0;
    localparam logic [14:0] RST_Q_DRIVE     = 15'd1638;
    localparam logic [15:0] RST_PWM_TOP     = 16'd999;

    // fixed-point constants
    localparam longint unsigned PI_HALF_Q30   = 64'd1686629713;
    localparam logic [15:0]     SQRT3_HALF_Q15 = 16'd28378;
    localparam logic signed [33:0] HALF_Q30   = 34'sd536870912;
    localparam logic signed [33:0] ONE_Q30    = 34'sd1073741824;

    // configuration register set
    typedef struct packed {
        logic        enable;
        logic [15:0] angle_step;
        logic [6:0]  pole_pairs;
        logic [15:0] zero_offset;
        logic [14:0] q_drive;
        logic [15:0] pwm_top;
    } olfp_cfg_t;

    // datapath commands issued by the controller
    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_CAPTURE,
        CMD_ELEC_MUL,
        CMD_ELEC,
        CMD_SIN_RD,
        CMD_COS_RD,
        CMD_COS_GET,
        CMD_MUL_S,
        CMD_MUL_C,
        CMD_MUL_K,
        CMD_VB,
        CMD_VC,
        CMD_DUTY_A,
        CMD_MUL_A,
        CMD_MUL_B,
        CMD_MUL_LAST,
        CMD_LOAD
    } olfp_cmd_t;

    // quarter-wave sine entry k in Q15, taylor series in Q30
    // evaluated at elaboration only
    function automatic logic [14:0] quarter_sine(int unsigned k, int unsigned qtr_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned q15;
        x    = (longint'(k) * PI_HALF_Q30) >> qtr_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = (term * x2) >> 30;
            case (n)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                default: term = term / 156;
            endcase
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q15 = (longint'(sum) + 16384) >> 15;
        if (q15 > 32767) begin
            q15 = 32767;
        end
        return q15[14:0];
    endfunction

endpackage

// ===== rtl/olfp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// olfp_cfg_regs
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
module olfp_cfg_regs
    import olfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output olfp_cfg_t   cfg
);

    olfp_cfg_t cfg_reg;

    // always ready to take a write
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable      <= RST_ENABLE;
            cfg_reg.angle_step  <= RST_ANGLE_STEP;
            cfg_reg.pole_pairs  <= RST_POLE_PAIRS;
            cfg_reg.zero_offset <= RST_ZERO_OFFSET;
            cfg_reg.q_drive     <= RST_Q_DRIVE;
            cfg_reg.pwm_top     <= RST_PWM_TOP;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ENABLE:      cfg_reg.enable      <= cfg_data[0];
                CFG_ANGLE_STEP:  cfg_reg.angle_step  <= cfg_data;
                CFG_POLE_PAIRS:  cfg_reg.pole_pairs  <= cfg_data[6:0];
                CFG_ZERO_OFFSET: cfg_reg.zero_offset <= cfg_data;
                CFG_Q_DRIVE:     cfg_reg.q_drive     <= cfg_data[14:0];
                CFG_PWM_TOP:     cfg_reg.pwm_top     <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/olfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// olfp_ctrl
// Sequencer stepping the datapath through one control tick and owning the
// input and result handshakes.
// ----------------------------------------------------------------------------
module olfp_ctrl
    import olfp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output olfp_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ELEC_MUL,
        ST_ELEC,
        ST_SIN_RD,
        ST_COS_RD,
        ST_COS_GET,
        ST_MUL_S,
        ST_MUL_C,
        ST_MUL_K,
        ST_VB,
        ST_VC,
        ST_DUTY_A,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_LAST,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // next state and command decode
    always_comb begin
        state_next   = state_reg;
        cmd          = CMD_NOP;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd        = CMD_CAPTURE;
                    state_next = ST_ELEC_MUL;
                end
            end
            ST_ELEC_MUL: begin cmd = CMD_ELEC_MUL; state_next = ST_ELEC;     end
            ST_ELEC:     begin cmd = CMD_ELEC;     state_next = ST_SIN_RD;   end
            ST_SIN_RD:   begin cmd = CMD_SIN_RD;   state_next = ST_COS_RD;   end
            ST_COS_RD:   begin cmd = CMD_COS_RD;   state_next = ST_COS_GET;  end
            ST_COS_GET:  begin cmd = CMD_COS_GET;  state_next = ST_MUL_S;    end
            ST_MUL_S:    begin cmd = CMD_MUL_S;    state_next = ST_MUL_C;    end
            ST_MUL_C:    begin cmd = CMD_MUL_C;    state_next = ST_MUL_K;    end
            ST_MUL_K:    begin cmd = CMD_MUL_K;    state_next = ST_VB;       end
            ST_VB:       begin cmd = CMD_VB;       state_next = ST_VC;       end
            ST_VC:       begin cmd = CMD_VC;       state_next = ST_DUTY_A;   end
            ST_DUTY_A:   begin cmd = CMD_DUTY_A;   state_next = ST_MUL_A;    end
            ST_MUL_A:    begin cmd = CMD_MUL_A;    state_next = ST_MUL_B;    end
            ST_MUL_B:    begin cmd = CMD_MUL_B;    state_next = ST_MUL_LAST; end
            ST_MUL_LAST: begin cmd = CMD_MUL_LAST; state_next = ST_DONE;     end
            ST_DONE: begin
                // wait for the output register to free up
                if (out_free) begin
                    cmd          = CMD_LOAD;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/olfp_datapath.sv =====
// ----------------------------------------------------------------------------
// olfp_datapath
// Shaft phase, electrical angle, sine rom, inverse park/clarke and compare
// scaling around one shared registered multiplier.
// ----------------------------------------------------------------------------
module olfp_datapath
    import olfp_pkg::*;
#(
    parameter int ANGLE_BITS      = 16,
    parameter int SINE_TABLE_BITS = 10
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  olfp_cmd_t   cmd,
    input  olfp_cfg_t   cfg,
    input  logic        s_advance,
    output logic [15:0] m_compare_a,
    output logic [15:0] m_compare_b,
    output logic [15:0] m_compare_c,
    output logic [15:0] m_electrical_angle
);

    localparam int STB      = SINE_TABLE_BITS;
    localparam int QB       = SINE_TABLE_BITS - 2;
    localparam int QTR_SIZE = 1 << QB;
    localparam logic [QB:0] QTR_ADDR = {1'b1, {QB{1'b0}}};

    // quarter-wave table, constant
    logic [14:0] qtab [QTR_SIZE+1];

    for (genvar g = 0; g <= QTR_SIZE; g++) begin : g_qtab
        assign qtab[g] = quarter_sine(g, QB);
    end

    logic [ANGLE_BITS-1:0]    phase_reg;
    logic [ANGLE_BITS-1:0]    elec_reg;
    logic                     neg_reg;
    logic [14:0]              rom_q_reg;
    logic signed [15:0]       s_reg;
    logic signed [15:0]       c_reg;
    logic signed [49:0]       prod_reg;
    logic signed [32:0]       qs_reg;
    logic signed [32:0]       vb_reg;
    logic signed [32:0]       vc_reg;
    logic [30:0]              duty_reg;
    logic [15:0]              cmp_a_reg;
    logic [15:0]              cmp_b_reg;
    logic [15:0]              out_a_reg;
    logic [15:0]              out_b_reg;
    logic [15:0]              out_c_reg;
    logic [15:0]              out_elec_reg;

    logic [ANGLE_BITS+15:0]    step_ext;
    logic [ANGLE_BITS+15:0]    off_ext;
    logic [ANGLE_BITS+15:0]    elec_ext;
    logic [ANGLE_BITS+STB-1:0] idx_wide;
    logic [STB-1:0]            idx;
    logic [STB-1:0]            cos_idx;
    logic [STB-1:0]            rd_idx;
    logic [1:0]                quad;
    logic [QB-1:0]             rem;
    logic [QB:0]               rom_addr;
    logic signed [15:0]        rom_val;
    logic signed [32:0]        mul_a;
    logic signed [16:0]        mul_b;
    logic                      mul_en;
    logic [15:0]               cmp_now;

    // clamp phase voltage plus half supply to [0, 1] in Q30
    function automatic logic [30:0] duty_of(logic signed [32:0] v);
        logic signed [33:0] d;
        d = 34'(v) + HALF_Q30;
        if (d < 0) begin
            return 31'd0;
        end else if (d > ONE_Q30) begin
            return ONE_Q30[30:0];
        end else begin
            return d[30:0];
        end
    endfunction

    // width adaptation of the 16-bit fields to the angle width
    assign step_ext = {{ANGLE_BITS{cfg.angle_step[15]}}, cfg.angle_step};
    assign off_ext  = {{ANGLE_BITS{1'b0}}, cfg.zero_offset};
    assign elec_ext = {16'd0, elec_reg};

    // table index from the electrical angle, sine and cosine folding
    assign idx_wide = {elec_reg, {STB{1'b0}}};
    assign idx      = idx_wide[ANGLE_BITS+STB-1 -: STB];
    assign cos_idx  = {idx[STB-1:QB] + 2'd1, idx[QB-1:0]};
    assign rd_idx   = (cmd == CMD_COS_RD) ? cos_idx : idx;
    assign quad     = rd_idx[STB-1:QB];
    assign rem      = rd_idx[QB-1:0];
    assign rom_addr = quad[0] ? (QTR_ADDR - {1'b0, rem}) : {1'b0, rem};
    assign rom_val  = neg_reg ? -$signed({1'b0, rom_q_reg}) : $signed({1'b0, rom_q_reg});

    assign cmp_now  = prod_reg[45:30];

    // shared multiplier operand select
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd)
            CMD_ELEC_MUL: begin
                mul_a = $signed(33'(phase_reg));
                mul_b = $signed(17'(cfg.pole_pairs));
            end
            CMD_MUL_S: begin
                mul_a = 33'(s_reg);
                mul_b = $signed(17'(cfg.q_drive));
            end
            CMD_MUL_C: begin
                mul_a = 33'(c_reg);
                mul_b = $signed(17'(cfg.q_drive));
            end
            CMD_MUL_K: begin
                mul_a = prod_reg[32:0];
                mul_b = $signed(17'(SQRT3_HALF_Q15));
            end
            CMD_MUL_A, CMD_MUL_B, CMD_MUL_LAST: begin
                mul_a = $signed({2'b00, duty_reg});
                mul_b = $signed({1'b0, cfg.pwm_top});
            end
            default: mul_en = 1'b0;
        endcase
    end

    // shaft phase, advanced as the item is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (cmd == CMD_CAPTURE && s_advance) begin
            phase_reg <= phase_reg + step_ext[ANGLE_BITS-1:0];
        end
    end

    // product register
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // datapath registers stepped by command
    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_ELEC: begin
                elec_reg <= prod_reg[ANGLE_BITS-1:0] + off_ext[ANGLE_BITS-1:0];
            end
            CMD_SIN_RD: begin
                rom_q_reg <= qtab[rom_addr];
                neg_reg   <= quad[1];
            end
            CMD_COS_RD: begin
                s_reg     <= rom_val;
                rom_q_reg <= qtab[rom_addr];
                neg_reg   <= quad[1];
            end
            CMD_COS_GET: begin
                c_reg <= rom_val;
            end
            CMD_MUL_C: begin
                // q times sine, which is minus alpha
                qs_reg <= prod_reg[32:0];
            end
            CMD_VB: begin
                vb_reg <= (qs_reg >>> 1) + $signed(prod_reg[47:15]);
            end
            CMD_VC: begin
                vc_reg <= qs_reg - vb_reg;
            end
            CMD_DUTY_A: begin
                duty_reg <= duty_of(-qs_reg);
            end
            CMD_MUL_A: begin
                duty_reg <= duty_of(vb_reg);
            end
            CMD_MUL_B: begin
                cmp_a_reg <= cmp_now;
                duty_reg  <= duty_of(vc_reg);
            end
            CMD_MUL_LAST: begin
                cmp_b_reg <= cmp_now;
            end
            CMD_LOAD: begin
                out_a_reg    <= cfg.enable ? cmp_a_reg : 16'd0;
                out_b_reg    <= cfg.enable ? cmp_b_reg : 16'd0;
                out_c_reg    <= cfg.enable ? cmp_now : 16'd0;
                out_elec_reg <= elec_ext[15:0];
            end
            default: ;
        endcase
    end

    assign m_compare_a        = out_a_reg;
    assign m_compare_b        = out_b_reg;
    assign m_compare_c        = out_c_reg;
    assign m_electrical_angle = out_elec_reg;

endmodule

// ===== rtl/open_loop_foc_pwm_unit.sv =====
// ----------------------------------------------------------------------------
// open_loop_foc_pwm_unit: open-loop sinusoidal PWM, one result per tick
// The sequencer steps each accepted beat through its states on one shared
// multiplier and takes no new beat until it is idle again. The output register
// lets the next tick start while a result waits. Synchronous reset.
// ----------------------------------------------------------------------------
module open_loop_foc_pwm_unit
    import olfp_pkg::*;
#(
    parameter int ANGLE_BITS      = 16,
    parameter int SINE_TABLE_BITS = 10
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_advance,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_compare_a,
    output logic [15:0] m_compare_b,
    output logic [15:0] m_compare_c,
    output logic [15:0] m_electrical_angle
);

    olfp_cfg_t cfg;
    olfp_cmd_t cmd;

    // configuration registers
    olfp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer
    olfp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // datapath
    olfp_datapath #(
        .ANGLE_BITS      (ANGLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .cfg                (cfg),
        .s_advance          (s_advance),
        .m_compare_a        (m_compare_a),
        .m_compare_b        (m_compare_b),
        .m_compare_c        (m_compare_c),
        .m_electrical_angle (m_electrical_angle)
    );

endmodule

// ===== test/open_loop_foc_pwm_unit_tb.sv =====
// ----------------------------------------------------------------------------
// open_loop_foc_pwm_unit_tb
// Self-checking bench for the open-loop sinusoidal PWM unit. A tick driver
// feeds advance beats from a queue and predicts the shaft angle, electrical
// angle and three compare values for every accepted beat. A result monitor
// checks each output beat against the oldest prediction. A directed sweep
// covers the extremes, then randomised register settings are run under
// several sender and receiver idling phases.
// ----------------------------------------------------------------------------
module open_loop_foc_pwm_unit_tb;
    import olfp_pkg::*;

    // fixed-point constants of the sine and duty arithmetic
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int              QTR_STEPS   = 256;
    localparam longint          SQRT3_BY2_Q15 = 64'sd28378;
    localparam longint          DUTY_MID    = 64'sd536870912;
    localparam longint          DUTY_FULL   = 64'sd1073741824;

    // indexes with no register behind them
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        logic        enable;
        logic [15:0] angle_step;
        logic [6:0]  pole_pairs;
        logic [15:0] zero_offset;
        logic [14:0] q_drive;
        logic [15:0] pwm_top;
    } drive_setup_t;

    typedef struct {
        logic [15:0] compare_a;
        logic [15:0] compare_b;
        logic [15:0] compare_c;
        logic [15:0] angle;
    } pwm_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_ENABLE;
    logic [15:0] cfg_data  = 16'd0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic        s_advance = 1'b0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [15:0] m_compare_a;
    logic [15:0] m_compare_b;
    logic [15:0] m_compare_c;
    logic [15:0] m_electrical_angle;

    // bench-side copy of the block state
    drive_setup_t setup;
    logic [15:0]  rotor_pos;
    int           quarter_wave [0:QTR_STEPS];

    bit          tick_queue [$];
    pwm_result_t pwm_expect_q [$];
    int          ticks_queued   = 0;
    int          ticks_accepted = 0;
    int          results_seen   = 0;
    int          mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    open_loop_foc_pwm_unit u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_advance          (s_advance),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_compare_a        (m_compare_a),
        .m_compare_b        (m_compare_b),
        .m_compare_c        (m_compare_c),
        .m_electrical_angle (m_electrical_angle)
    );

    always #2 aclk = ~aclk;

    // taylor series sine over one quarter turn, rounded to Q15
    function automatic int quarter_entry(int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned rounded;
        longint          sum;
        x    = (longint'(k) * HALF_PI_Q30) >> 8;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        rounded = sum + 16384;
        rounded = rounded >> 15;
        if (rounded > 32767) begin
            rounded = 32767;
        end
        return int'(rounded);
    endfunction

    // full-turn sine from the quarter table: bit 8 mirrors, bit 9 negates
    function automatic longint sine_at(logic [9:0] i);
        longint mag;
        if (i[8]) begin
            mag = quarter_wave[QTR_STEPS - int'(i[7:0])];
        end else begin
            mag = quarter_wave[int'(i[7:0])];
        end
        return i[9] ? -mag : mag;
    endfunction

    // phase voltage in Q30 to compare count, duty clamped to [0,1]
    function automatic logic [15:0] duty_to_compare(longint v);
        longint duty;
        longint top;
        duty = v + DUTY_MID;
        if (duty < 0) begin
            duty = 0;
        end else if (duty > DUTY_FULL) begin
            duty = DUTY_FULL;
        end
        top = setup.pwm_top;
        return 16'((duty * top) >>> 30);
    endfunction

    // one control tick: step the shaft, then inverse park and clarke
    function automatic pwm_result_t predict_tick(bit adv);
        pwm_result_t r;
        logic [31:0] wide;
        logic [9:0]  idx;
        longint      sn;
        longint      cs;
        longint      alpha;
        longint      beta;
        longint      va;
        longint      vb;
        longint      vc;
        if (adv) begin
            rotor_pos = rotor_pos + setup.angle_step;
        end
        wide    = rotor_pos * setup.pole_pairs + setup.zero_offset;
        r.angle = wide[15:0];
        idx     = wide[15:6];
        if (setup.enable) begin
            sn    = sine_at(idx);
            cs    = sine_at(idx + 10'd256);
            alpha = -(longint'(setup.q_drive) * sn);
            beta  = longint'(setup.q_drive) * cs;
            va    = alpha;
            vb    = ((-alpha) >>> 1) + ((beta * SQRT3_BY2_Q15) >>> 15);
            vc    = -va - vb;
            r.compare_a = duty_to_compare(va);
            r.compare_b = duty_to_compare(vb);
            r.compare_c = duty_to_compare(vc);
        end else begin
            r.compare_a = 16'd0;
            r.compare_b = 16'd0;
            r.compare_c = 16'd0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    // register write; valid is left high so back-to-back writes need no gap
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        case (idx)
            CFG_ENABLE:      setup.enable      = val[0];
            CFG_ANGLE_STEP:  setup.angle_step  = val;
            CFG_POLE_PAIRS:  setup.pole_pairs  = val[6:0];
            CFG_ZERO_OFFSET: setup.zero_offset = val;
            CFG_Q_DRIVE:     setup.q_drive     = val[14:0];
            CFG_PWM_TOP:     setup.pwm_top     = val;
            default: ;
        endcase
    endtask

    task automatic push_tick(bit adv);
        tick_queue.push_back(adv);
        ticks_queued++;
    endtask

    // wait for every tick to be taken and every result to come back
    task automatic wait_idle();
        while (ticks_accepted != ticks_queued || pwm_expect_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // random register set, biased towards the extremes now and then
    task automatic shuffle_setup();
        logic [15:0] val;
        val    = 16'($urandom);
        val[0] = ($urandom_range(9) != 0);
        write_reg(CFG_ENABLE, val);
        if ($urandom_range(3) == 0) begin
            val = 16'($signed($urandom_range(128)) - 64);
        end else begin
            val = 16'($urandom);
        end
        write_reg(CFG_ANGLE_STEP, val);
        if ($urandom_range(4) == 0) begin
            val = 16'($urandom);
        end else begin
            val = 16'($urandom_range(64, 1));
        end
        write_reg(CFG_POLE_PAIRS, val);
        write_reg(CFG_ZERO_OFFSET, 16'($urandom));
        case ($urandom_range(5))
            0:       val = 16'h7FFF;
            1:       val = 16'h0000;
            default: val = 16'($urandom);
        endcase
        write_reg(CFG_Q_DRIVE, val);
        case ($urandom_range(7))
            0:       val = 16'hFFFF;
            1:       val = 16'h0000;
            2:       val = 16'h0001;
            default: val = 16'($urandom_range(65535, 1));
        endcase
        write_reg(CFG_PWM_TOP, val);
        if ($urandom_range(6) == 0) begin
            write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    // tick driver: presents queued beats and predicts each accepted one
    always @(posedge aclk) begin : tick_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pwm_expect_q.push_back(predict_tick(s_advance));
                ticks_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_advance <= tick_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compares each output beat with the oldest prediction
    always @(posedge aclk) begin : result_monitor
        pwm_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pwm_expect_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none pending",
                                              results_seen));
                end else begin
                    want = pwm_expect_q.pop_front();
                    if (m_compare_a !== want.compare_a) begin
                        report_mismatch($sformatf("result %0d compare_a %h, expected %h",
                                                  results_seen, m_compare_a, want.compare_a));
                    end
                    if (m_compare_b !== want.compare_b) begin
                        report_mismatch($sformatf("result %0d compare_b %h, expected %h",
                                                  results_seen, m_compare_b, want.compare_b));
                    end
                    if (m_compare_c !== want.compare_c) begin
                        report_mismatch($sformatf("result %0d compare_c %h, expected %h",
                                                  results_seen, m_compare_c, want.compare_c));
                    end
                    if (m_electrical_angle !== want.angle) begin
                        report_mismatch($sformatf("result %0d angle %h, expected %h",
                                                  results_seen, m_electrical_angle,
                                                  want.angle));
                    end
                end
                results_seen++;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // stimulus sequence
    initial begin : stimulus
        int n_ticks;
        for (int k = 0; k <= QTR_STEPS; k++) begin
            quarter_wave[k] = quarter_entry(k);
        end
        setup.enable      = 1'b0;
        setup.angle_step  = 16'd0;
        setup.pole_pairs  = 7'd7;
        setup.zero_offset = 16'd0;
        setup.q_drive     = 15'd1638;
        setup.pwm_top     = 16'd999;
        rotor_pos         = 16'd0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // values after reset: disabled, angle still reported
        push_tick(1'b0);
        push_tick(1'b1);
        wait_idle();

        // full drive, quarter-turn steps through every quadrant
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_Q_DRIVE, 16'h7FFF);
        write_reg(CFG_PWM_TOP, 16'hFFFF);
        write_reg(CFG_POLE_PAIRS, 16'd1);
        write_reg(CFG_ANGLE_STEP, 16'h4000);
        write_reg(CFG_ZERO_OFFSET, 16'd0);
        cfg_valid <= 1'b0;
        push_tick(1'b0);
        repeat (4) push_tick(1'b1);
        wait_idle();

        // backwards by one, 64 pole pairs, largest offset, top of one
        write_reg(CFG_ANGLE_STEP, 16'hFFFF);
        write_reg(CFG_POLE_PAIRS, 16'd64);
        write_reg(CFG_ZERO_OFFSET, 16'hFFFF);
        write_reg(CFG_PWM_TOP, 16'd1);
        cfg_valid <= 1'b0;
        push_tick(1'b1);
        push_tick(1'b1);
        push_tick(1'b0);
        wait_idle();

        // zero pole pairs gives the offset alone; zero top gives zero compares
        write_reg(CFG_POLE_PAIRS, 16'd0);
        write_reg(CFG_PWM_TOP, 16'd0);
        cfg_valid <= 1'b0;
        push_tick(1'b1);
        push_tick(1'b1);
        wait_idle();

        // writes wider than the registers; enable bit clear disables
        write_reg(CFG_PWM_TOP, 16'd999);
        write_reg(CFG_POLE_PAIRS, 16'hFFFF);
        write_reg(CFG_Q_DRIVE, 16'hFFFF);
        write_reg(CFG_ENABLE, 16'hFFFE);
        cfg_valid <= 1'b0;
        push_tick(1'b1);
        push_tick(1'b0);
        wait_idle();

        // most negative step, writes to unmapped indexes are dropped
        write_reg(CFG_ENABLE, 16'h0003);
        write_reg(CFG_ANGLE_STEP, 16'h8000);
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0000);
        cfg_valid <= 1'b0;
        push_tick(1'b1);
        push_tick(1'b1);
        wait_idle();

        // most positive step with no q drive: all phases sit at half duty
        write_reg(CFG_ANGLE_STEP, 16'h7FFF);
        write_reg(CFG_Q_DRIVE, 16'd0);
        cfg_valid <= 1'b0;
        push_tick(1'b1);
        push_tick(1'b0);
        wait_idle();

        // random settings, rotating through the idling phases
        for (int seg = 0; seg < 20; seg++) begin
            shuffle_setup();
            case (seg % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                end
                default: begin
                    send_idle_pct  = 26;
                    recv_stall_pct = 26;
                end
            endcase
            n_ticks = $urandom_range(105, 80);
            for (int i = 0; i < n_ticks; i++) begin
                push_tick($urandom_range(4) != 0);
            end
            wait_idle();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/olfp_pkg.sv
rtl/olfp_cfg_regs.sv
rtl/olfp_ctrl.sv
rtl/olfp_datapath.sv
rtl/open_loop_foc_pwm_unit.sv
test/open_loop_foc_pwm_unit_tb.sv
